@@ sv/pid_arm_closed_loop_step_assert.svh @@
// Assertion macros for the arm controller checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PID_ARM_CLOSED_LOOP_STEP_ASSERT_SVH
`define PID_ARM_CLOSED_LOOP_STEP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PACL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pacl_pkg.sv @@
// Shared types, constants and saturating fixed-point helpers for the arm controller.
// No dependencies; every other file but the assertion macro header imports this package.
`default_nettype none

package pacl_pkg;

  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * VAL_W + 1;
  localparam int SH_W       = PROD_W - FRAC_W;
  localparam int GAIN_W     = 24;
  localparam int DT_W       = 16;
  localparam int IDT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_STEP_TIME = 3'd3,
    REG_INV_STEP  = 3'd4,
    REG_INV_INRT  = 3'd5,
    REG_TARGET    = 3'd6
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] RST_GAIN_P    = 24'd65536;
  localparam logic [GAIN_W-1:0] RST_GAIN_I    = 24'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN_D    = 24'd6554;
  localparam logic [DT_W-1:0]   RST_STEP_TIME = 16'd6554;
  localparam logic [IDT_W-1:0]  RST_INV_STEP  = 32'd655360;
  localparam logic [GAIN_W-1:0] RST_INV_INRT  = 24'd65536;
  localparam val_t              RST_TARGET    = -32'sd102944;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [DT_W-1:0]   step_time;
    logic [IDT_W-1:0]  inv_step_time;
    logic [GAIN_W-1:0] inv_inertia;
    val_t              target_angle;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_ERR_DT,
    MS_DIFF_IDT,
    MS_ERR_KP,
    MS_SUM_KI,
    MS_DER_KD,
    MS_TRQ_IINV,
    MS_ACC_DT,
    MS_VEL_DT
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_SUM,
    WB_DERIV,
    WB_TRQ_SET,
    WB_TRQ_ADD,
    WB_ACCEL,
    WB_VEL,
    WB_ANGLE
  } wb_sel_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

  function automatic val_t sat_fit(input logic signed [VAL_W:0] s);
    val_t r;
    if (s[VAL_W] != s[VAL_W-1]) begin
      r = s[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r = s[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    return sat_fit(s);
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    return sat_fit(s);
  endfunction

  // Scales a full product back to the value format, truncating toward zero,
  // and clamps it to the value range.
  function automatic val_t sat_post(input prod_t p);
    prod_t                 adj;
    logic [SH_W-1:0]       sh;
    logic [SH_W-VAL_W:0]   hi;
    val_t                  r;
    adj = p + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{p[PROD_W-1]}}});
    sh  = adj[PROD_W-1:FRAC_W];
    hi  = sh[SH_W-1:VAL_W-1];
    if (hi == '0 || hi == '1) begin
      r = sh[VAL_W-1:0];
    end else begin
      r = sh[SH_W-1] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/pacl_if.sv @@
// Handshake channel interfaces for the arm controller: input, result and configuration.
// Depends on pacl_pkg for widths.
`default_nettype none

interface pacl_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic hold_plant;

  modport source (output valid, restart, hold_plant, input ready);
  modport sink (input valid, restart, hold_plant, output ready);
endinterface

interface pacl_out_if;
  import pacl_pkg::*;
  logic valid;
  logic ready;
  val_t arm_angle;
  val_t arm_velocity;
  val_t drive_torque;
  val_t control_error;

  modport source (output valid, arm_angle, arm_velocity, drive_torque, control_error,
                  input ready);
  modport sink (input valid, arm_angle, arm_velocity, drive_torque, control_error,
                output ready);
endinterface

interface pacl_cfg_if;
  import pacl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/pacl_cfg.sv @@
// Configuration register file for the arm controller.
// Depends on pacl_pkg and the pacl_cfg_if interface.
`default_nettype none

module pacl_cfg
  import pacl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pacl_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p        <= RST_GAIN_P;
      cfg_r.gain_i        <= RST_GAIN_I;
      cfg_r.gain_d        <= RST_GAIN_D;
      cfg_r.step_time     <= RST_STEP_TIME;
      cfg_r.inv_step_time <= RST_INV_STEP;
      cfg_r.inv_inertia   <= RST_INV_INRT;
      cfg_r.target_angle  <= RST_TARGET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GAIN_P:    cfg_r.gain_p        <= cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_I:    cfg_r.gain_i        <= cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_D:    cfg_r.gain_d        <= cfg_ch.data[GAIN_W-1:0];
        REG_STEP_TIME: cfg_r.step_time     <= cfg_ch.data[DT_W-1:0];
        REG_INV_STEP:  cfg_r.inv_step_time <= cfg_ch.data[IDT_W-1:0];
        REG_INV_INRT:  cfg_r.inv_inertia   <= cfg_ch.data[GAIN_W-1:0];
        REG_TARGET:    cfg_r.target_angle  <= $signed(cfg_ch.data[VAL_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/pacl_ctrl.sv @@
// Sequencer for one control tick: issues start, multiplier, write-back and publish commands.
// Depends on pacl_pkg and the pacl_in_if interface.
`default_nettype none

module pacl_ctrl
  import pacl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  pacl_in_if.sink      in_ch,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_ERR_DT,
    ST_M_DIFF,
    ST_M_KP,
    ST_M_KI,
    ST_M_KD,
    ST_W_KD,
    ST_M_IINV,
    ST_W_ACC,
    ST_M_ACC_DT,
    ST_W_VEL,
    ST_M_VEL_DT,
    ST_W_ANG,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   hold_r;
  logic   accept;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.start   = 1'b0;
    cmd.mul_sel = MS_ERR_DT;
    cmd.wb_sel  = WB_NONE;
    cmd.publish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.start = accept;
        if (accept) state_nxt = ST_M_ERR_DT;
      end
      ST_M_ERR_DT: begin
        cmd.mul_sel = MS_ERR_DT;
        state_nxt   = ST_M_DIFF;
      end
      ST_M_DIFF: begin
        cmd.mul_sel = MS_DIFF_IDT;
        cmd.wb_sel  = WB_SUM;
        state_nxt   = ST_M_KP;
      end
      ST_M_KP: begin
        cmd.mul_sel = MS_ERR_KP;
        cmd.wb_sel  = WB_DERIV;
        state_nxt   = ST_M_KI;
      end
      ST_M_KI: begin
        cmd.mul_sel = MS_SUM_KI;
        cmd.wb_sel  = WB_TRQ_SET;
        state_nxt   = ST_M_KD;
      end
      ST_M_KD: begin
        cmd.mul_sel = MS_DER_KD;
        cmd.wb_sel  = WB_TRQ_ADD;
        state_nxt   = ST_W_KD;
      end
      ST_W_KD: begin
        cmd.wb_sel = WB_TRQ_ADD;
        state_nxt  = hold_r ? ST_FINISH : ST_M_IINV;
      end
      ST_M_IINV: begin
        cmd.mul_sel = MS_TRQ_IINV;
        state_nxt   = ST_W_ACC;
      end
      ST_W_ACC: begin
        cmd.wb_sel = WB_ACCEL;
        state_nxt  = ST_M_ACC_DT;
      end
      ST_M_ACC_DT: begin
        cmd.mul_sel = MS_ACC_DT;
        state_nxt   = ST_W_VEL;
      end
      ST_W_VEL: begin
        cmd.wb_sel = WB_VEL;
        state_nxt  = ST_M_VEL_DT;
      end
      ST_M_VEL_DT: begin
        cmd.mul_sel = MS_VEL_DT;
        state_nxt   = ST_W_ANG;
      end
      ST_W_ANG: begin
        cmd.wb_sel = WB_ANGLE;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) hold_r <= in_ch.hold_plant;
    end
  end

endmodule

`default_nettype wire

@@ sv/pacl_dp.sv @@
// Datapath for the arm controller: state registers, shared multiplier, write-back
// and result register. Depends on pacl_pkg and the pacl_out_if interface.
`default_nettype none

module pacl_dp
  import pacl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire cmd_t  cmd,
  input  wire logic  restart,
  output status_t    status,
  pacl_out_if.source out_ch
);

  val_t  err_r, diff_r, sum_r, last_err_r, deriv_r, torque_r, accel_r, vel_r, angle_r;
  prod_t prod_r, prod_nxt;
  val_t  wb_val;
  val_t  mul_a;
  logic  [IDT_W-1:0] mul_b;
  logic  signed [VAL_W:0] mul_a_ext;
  logic  signed [IDT_W:0] mul_b_ext;
  val_t  angle_start;

  val_t  out_angle_r, out_vel_r, out_torque_r, out_err_r;
  logic  out_valid_r;

  always_comb begin
    case (cmd.mul_sel)
      MS_ERR_DT: begin
        mul_a = err_r;
        mul_b = IDT_W'(cfg.step_time);
      end
      MS_DIFF_IDT: begin
        mul_a = diff_r;
        mul_b = cfg.inv_step_time;
      end
      MS_ERR_KP: begin
        mul_a = err_r;
        mul_b = IDT_W'(cfg.gain_p);
      end
      MS_SUM_KI: begin
        mul_a = sum_r;
        mul_b = IDT_W'(cfg.gain_i);
      end
      MS_DER_KD: begin
        mul_a = deriv_r;
        mul_b = IDT_W'(cfg.gain_d);
      end
      MS_TRQ_IINV: begin
        mul_a = torque_r;
        mul_b = IDT_W'(cfg.inv_inertia);
      end
      MS_ACC_DT: begin
        mul_a = accel_r;
        mul_b = IDT_W'(cfg.step_time);
      end
      MS_VEL_DT: begin
        mul_a = vel_r;
        mul_b = IDT_W'(cfg.step_time);
      end
      default: begin
        mul_a = err_r;
        mul_b = '0;
      end
    endcase
  end

  assign mul_a_ext   = {mul_a[VAL_W-1], mul_a};
  assign mul_b_ext   = $signed({1'b0, mul_b});
  assign prod_nxt    = mul_a_ext * mul_b_ext;
  assign wb_val      = sat_post(prod_r);
  assign angle_start = restart ? '0 : angle_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      last_err_r <= '0;
      vel_r      <= '0;
      angle_r    <= '0;
    end else begin
      if (cmd.start && restart) begin
        last_err_r <= '0;
        vel_r      <= '0;
        angle_r    <= '0;
      end
      case (cmd.wb_sel)
        WB_SUM:   sum_r <= sat_add(sum_r, wb_val);
        WB_DERIV: last_err_r <= err_r;
        WB_VEL:   vel_r <= sat_add(vel_r, wb_val);
        WB_ANGLE: angle_r <= sat_add(angle_r, wb_val);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) err_r <= sat_sub(cfg.target_angle, angle_start);
    if (cmd.mul_sel == MS_ERR_DT) diff_r <= sat_sub(err_r, last_err_r);
    case (cmd.wb_sel)
      WB_DERIV:   deriv_r  <= wb_val;
      WB_TRQ_SET: torque_r <= wb_val;
      WB_TRQ_ADD: torque_r <= sat_add(torque_r, wb_val);
      WB_ACCEL:   accel_r  <= wb_val;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_angle_r  <= angle_r;
      out_vel_r    <= vel_r;
      out_torque_r <= torque_r;
      out_err_r    <= err_r;
    end
  end

  assign status.out_full      = out_valid_r && !out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.arm_angle     = out_angle_r;
  assign out_ch.arm_velocity  = out_vel_r;
  assign out_ch.drive_torque  = out_torque_r;
  assign out_ch.control_error = out_err_r;

endmodule

`default_nettype wire

@@ sv/pid_arm_closed_loop_step.sv @@
// Top level of the closed-loop PID arm controller: configuration, sequencer and datapath.
// Depends on pacl_pkg, the channel interfaces, pacl_cfg, pacl_ctrl and pacl_dp.
//
// Each accepted request runs one control tick and returns one result with the arm
// angle, velocity, drive torque and control error, all signed Q16.16 and saturated.
// Requests are taken only while the block is idle. The result register is loaded at the
// end of the tick, which skips the plant update when the plant is held, and the next
// request can be accepted once the block is back in the idle state. The time is set by
// the eight products, or five when the plant is held, sharing one 33 by 33 bit multiplier
// whose registered product is written back in the following cycle. The result register
// lets a new request be accepted while the previous result waits; the next result is
// written only after that one has been taken.
// Configuration writes are accepted in every cycle.
`default_nettype none

module pid_arm_closed_loop_step
  import pacl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pacl_in_if.sink    in_ch,
  pacl_out_if.source out_ch,
  pacl_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pacl_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pacl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .status (status),
    .cmd    (cmd)
  );

  pacl_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .cmd     (cmd),
    .restart (in_ch.restart),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ sv/pacl_checker.sv @@
// Port-level checker for the arm controller and its bind to the top level.
// Depends on pacl_pkg and the assertion macro header.
`default_nettype none

`include "pid_arm_closed_loop_step_assert.svh"

module pacl_checker
  import pacl_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire val_t out_angle,
  input wire val_t out_vel,
  input wire val_t out_torque,
  input wire val_t out_err
);

  logic [4*VAL_W-1:0] out_payload;
  logic               in_accept;
  logic               out_stall;

  assign out_payload = {out_angle, out_vel, out_torque, out_err};
  assign in_accept   = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;

  // A result that is not taken stays offered with the same contents.
  `PACL_ASSERT_NEXT(a_out_valid_hold, out_stall, out_valid, "result dropped while stalled")
  `PACL_ASSERT_NEXT(a_out_data_hold, out_stall, $stable(out_payload), "result changed while stalled")
  // One request at a time: the block is busy right after it takes a request.
  `PACL_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready, "request taken while busy")
  // A new result only appears at the end of a tick, never from the idle state.
  `PACL_ASSERT_SAME(a_result_from_tick, $rose(out_valid), $past(!in_ready), "result without a tick")

endmodule

bind pid_arm_closed_loop_step pacl_checker u_pacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_angle  (out_ch.arm_angle),
  .out_vel    (out_ch.arm_velocity),
  .out_torque (out_ch.drive_torque),
  .out_err    (out_ch.control_error)
);

`default_nettype wire
